// ===== rtl/core/hsvrgb_pkg.sv =====
// Package with the widths and fixed-point constants of the HSV to RGB pixel converter.
package hsvrgb_pkg;

	localparam int HUE_W   = 15;
	localparam int PCT_W   = 7;
	localparam int BYTE_W  = 8;
	localparam int SEC_W   = 3;
	localparam int OFS_W   = 12;
	localparam int K_W     = 19;
	localparam int N_W     = 26;
	localparam int X_W     = 31;
	localparam int Y_W     = 19;
	localparam int RECIP_W = 20;
	localparam int PROD_W  = Y_W + RECIP_W;
	localparam int RECIP_SH = 30;
	localparam int X_SH    = 12;

	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 32;

	// Hue is degrees times 64; one sector is 60 degrees.
	localparam logic [HUE_W-1:0] HUE_FULL   = HUE_W'(23040);
	localparam logic [HUE_W-1:0] HUE_SECTOR = HUE_W'(3840);
	localparam logic [PCT_W-1:0] PCT_FULL   = PCT_W'(100);
	localparam logic [K_W-1:0]   K_FULL     = K_W'(384000);

	// Channel byte = floor((51*N + 3840000) / 7680000), and 7680000 = 2^12 * 1875.
	localparam logic [X_W-1:0]     ROUND_BIAS = X_W'(3840000);
	localparam logic [5:0]         SCALE_MUL  = 6'd51;
	// ceil(2^30 / 1875): exact quotient for every 19-bit dividend.
	localparam logic [RECIP_W-1:0] RECIP_1875 = RECIP_W'(572663);

	localparam logic [BYTE_W-1:0] BYTE_MAX = 8'hFF;

	localparam logic [SEC_W-1:0] SEC_0 = 3'd0;
	localparam logic [SEC_W-1:0] SEC_1 = 3'd1;
	localparam logic [SEC_W-1:0] SEC_2 = 3'd2;
	localparam logic [SEC_W-1:0] SEC_3 = 3'd3;
	localparam logic [SEC_W-1:0] SEC_4 = 3'd4;
	localparam logic [SEC_W-1:0] SEC_5 = 3'd5;

endpackage

// ===== rtl/core/hsv_to_rgb_pixel_convert.sv =====
// Top level of the five-stage HSV-plus-alpha to 8-bit RGBA pixel converter.
// An accepted input transaction passes the stage registers s1 to s5 before m_tvalid.
// Throughput: one pixel per clock; each stage holds one pixel, and the per-stage
// ready chain lets a stalled output fill upstream bubbles before s_tready drops.
// Of the five registered arithmetic stages, the deepest is the reciprocal
// multiply that replaces the division by 1875.
// Reset (arst_n low, asynchronous) empties every stage; payload is not reset.
module hsv_to_rgb_pixel_convert (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// s_tdata: hue[14:0], saturation[21:15], brightness[28:22], alpha_in[36:29], zero[39:37]
	input  logic [hsvrgb_pkg::S_TDATA_W-1:0]  s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// m_tdata: red[7:0], green[15:8], blue[23:16], alpha_out[31:24]
	output logic [hsvrgb_pkg::M_TDATA_W-1:0]  m_tdata
);
	import hsvrgb_pkg::*;

	// Per-stage ready: a stage may load when it is empty or its content moves on.
	logic rdy1, rdy2, rdy3, rdy4, rdy5;
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;

	assign rdy5     = !valid_s5 || m_tready;
	assign rdy4     = !valid_s4 || rdy5;
	assign rdy3     = !valid_s3 || rdy4;
	assign rdy2     = !valid_s2 || rdy3;
	assign rdy1     = !valid_s1 || rdy2;
	assign s_tready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= s_tvalid;
			if (rdy2) valid_s2 <= valid_s1;
			if (rdy3) valid_s3 <= valid_s2;
			if (rdy4) valid_s4 <= valid_s3;
			if (rdy5) valid_s5 <= valid_s4;
		end
	end

	// Stage 1: unpack, clamp the inputs to their legal range and split the hue
	// into its 60-degree sector and the offset within that sector.
	logic [HUE_W-1:0]  hue_in, hue_c;
	logic [PCT_W-1:0]  sat_in, bri_in, sat_c, bri_c;
	logic [BYTE_W-1:0] alpha_in;
	logic [SEC_W-1:0]  sec_c;
	logic [HUE_W-1:0]  ofs_c;

	assign hue_in   = s_tdata[14:0];
	assign sat_in   = s_tdata[21:15];
	assign bri_in   = s_tdata[28:22];
	assign alpha_in = s_tdata[36:29];

	// A hue at or beyond a full turn is taken as zero.
	assign hue_c = (hue_in >= HUE_FULL) ? '0 : hue_in;
	assign sat_c = (sat_in > PCT_FULL) ? PCT_FULL : sat_in;
	assign bri_c = (bri_in > PCT_FULL) ? PCT_FULL : bri_in;

	always_comb begin
		if (hue_c >= HUE_W'(5 * 3840)) begin
			sec_c = SEC_5;
			ofs_c = hue_c - HUE_W'(5 * 3840);
		end else if (hue_c >= HUE_W'(4 * 3840)) begin
			sec_c = SEC_4;
			ofs_c = hue_c - HUE_W'(4 * 3840);
		end else if (hue_c >= HUE_W'(3 * 3840)) begin
			sec_c = SEC_3;
			ofs_c = hue_c - HUE_W'(3 * 3840);
		end else if (hue_c >= HUE_W'(2 * 3840)) begin
			sec_c = SEC_2;
			ofs_c = hue_c - HUE_W'(2 * 3840);
		end else if (hue_c >= HUE_SECTOR) begin
			sec_c = SEC_1;
			ofs_c = hue_c - HUE_SECTOR;
		end else begin
			sec_c = SEC_0;
			ofs_c = hue_c;
		end
	end

	logic [SEC_W-1:0]  sec_s1;
	logic [OFS_W-1:0]  ofs_s1;
	logic [PCT_W-1:0]  sat_s1, bri_s1;
	logic [BYTE_W-1:0] alpha_s1;

	always_ff @(posedge clk) begin
		if (rdy1 && s_tvalid) begin
			sec_s1   <= sec_c;
			ofs_s1   <= ofs_c[OFS_W-1:0];
			sat_s1   <= sat_c;
			bri_s1   <= bri_c;
			alpha_s1 <= alpha_in;
		end
	end

	// Stage 2: the scaled channel factors k for p, q and t (the value channel
	// uses the full-scale constant). Zero saturation makes all of them full scale,
	// which yields the grey case without a branch of its own.
	logic [K_W-1:0] kp_c, kq_c, kt_c;
	logic [OFS_W-1:0] rem_c;

	assign rem_c = OFS_W'(HUE_SECTOR) - ofs_s1;
	assign kp_c  = K_W'(PCT_FULL - sat_s1) * K_W'(HUE_SECTOR);
	assign kq_c  = K_FULL - K_W'(sat_s1) * K_W'(ofs_s1);
	assign kt_c  = K_FULL - K_W'(sat_s1) * K_W'(rem_c);

	logic [SEC_W-1:0]  sec_s2;
	logic [PCT_W-1:0]  bri_s2;
	logic [BYTE_W-1:0] alpha_s2;
	logic [K_W-1:0]    kp_s2, kq_s2, kt_s2;

	always_ff @(posedge clk) begin
		if (rdy2 && valid_s1) begin
			sec_s2   <= sec_s1;
			bri_s2   <= bri_s1;
			alpha_s2 <= alpha_s1;
			kp_s2    <= kp_c;
			kq_s2    <= kq_c;
			kt_s2    <= kt_c;
		end
	end

	// Stage 3: channel numerators N = brightness * k.
	logic [SEC_W-1:0]  sec_s3;
	logic [BYTE_W-1:0] alpha_s3;
	logic [N_W-1:0]    nv_s3, np_s3, nq_s3, nt_s3;

	always_ff @(posedge clk) begin
		if (rdy3 && valid_s2) begin
			sec_s3   <= sec_s2;
			alpha_s3 <= alpha_s2;
			nv_s3    <= N_W'(bri_s2) * N_W'(K_FULL);
			np_s3    <= N_W'(bri_s2) * N_W'(kp_s2);
			nq_s3    <= N_W'(bri_s2) * N_W'(kq_s2);
			nt_s3    <= N_W'(bri_s2) * N_W'(kt_s2);
		end
	end

	// Stage 4: scale to 255 with the rounding bias, then drop the power-of-two
	// part of the divisor.
	function automatic logic [Y_W-1:0] scale_bias(input logic [N_W-1:0] n);
		logic [X_W-1:0] x;
		x = X_W'(n) * X_W'(SCALE_MUL) + ROUND_BIAS;
		return x[X_W-1:X_SH];
	endfunction

	logic [SEC_W-1:0]  sec_s4;
	logic [BYTE_W-1:0] alpha_s4;
	logic [Y_W-1:0]    yv_s4, yp_s4, yq_s4, yt_s4;

	always_ff @(posedge clk) begin
		if (rdy4 && valid_s3) begin
			sec_s4   <= sec_s3;
			alpha_s4 <= alpha_s3;
			yv_s4    <= scale_bias(nv_s3);
			yp_s4    <= scale_bias(np_s3);
			yq_s4    <= scale_bias(nq_s3);
			yt_s4    <= scale_bias(nt_s3);
		end
	end

	// Stage 5: divide by 1875 through the reciprocal, saturate to a byte and
	// order the channels by sector.
	function automatic logic [PROD_W-RECIP_SH-1:0] div_1875(input logic [Y_W-1:0] y);
		logic [PROD_W-1:0] prod;
		prod = PROD_W'(y) * PROD_W'(RECIP_1875);
		return prod[PROD_W-1:RECIP_SH];
	endfunction

	logic [PROD_W-RECIP_SH-1:0] qv_raw, qp_raw, qq_raw, qt_raw;
	logic [BYTE_W-1:0] cv, cp, cq, ct;
	logic [BYTE_W-1:0] red_c, green_c, blue_c;

	assign qv_raw = div_1875(yv_s4);
	assign qp_raw = div_1875(yp_s4);
	assign qq_raw = div_1875(yq_s4);
	assign qt_raw = div_1875(yt_s4);

	assign cv = qv_raw[PROD_W-RECIP_SH-1] ? BYTE_MAX : qv_raw[BYTE_W-1:0];
	assign cp = qp_raw[PROD_W-RECIP_SH-1] ? BYTE_MAX : qp_raw[BYTE_W-1:0];
	assign cq = qq_raw[PROD_W-RECIP_SH-1] ? BYTE_MAX : qq_raw[BYTE_W-1:0];
	assign ct = qt_raw[PROD_W-RECIP_SH-1] ? BYTE_MAX : qt_raw[BYTE_W-1:0];

	always_comb begin
		unique case (sec_s4)
			SEC_0: begin red_c = cv; green_c = ct; blue_c = cp; end
			SEC_1: begin red_c = cq; green_c = cv; blue_c = cp; end
			SEC_2: begin red_c = cp; green_c = cv; blue_c = ct; end
			SEC_3: begin red_c = cp; green_c = cq; blue_c = cv; end
			SEC_4: begin red_c = ct; green_c = cp; blue_c = cv; end
			default: begin red_c = cv; green_c = cp; blue_c = cq; end
		endcase
	end

	logic [M_TDATA_W-1:0] out_s5;

	always_ff @(posedge clk) begin
		if (rdy5 && valid_s4) begin
			out_s5 <= {alpha_s4, blue_c, green_c, red_c};
		end
	end

	assign m_tvalid = valid_s5;
	assign m_tdata  = out_s5;

	// The reciprocal division never exceeds a byte for a legal pixel.
	a_quot_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 |-> (qv_raw <= 9'd255 && qp_raw <= 9'd255 &&
			qq_raw <= 9'd255 && qt_raw <= 9'd255))
		else $error("channel quotient above 255");

	// The p, q and t factors stay within full scale, so the subtraction did not wrap.
	a_k_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (kq_s2 <= K_FULL && kt_s2 <= K_FULL && kp_s2 <= K_FULL))
		else $error("channel factor above full scale");

	// With every stage occupied and the output stalled, no new pixel is taken.
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && valid_s3 && valid_s4 && valid_s5 && !m_tready)
			|-> !s_tready)
		else $error("input accepted into a full stalled pipeline");

	// A pixel in the last stage that is not taken stays there for the next cycle, and so does the one in stage 4.
	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s4 && valid_s5 && !m_tready) |=> (valid_s5 && valid_s4))
		else $error("stalled pixels dropped from the last stages");

endmodule
